// ----- rtl/button_press_channel_mode_fsm_macros.svh -----
// Assertion macros shared by the button press channel mode machine.
`ifndef BUTTON_PRESS_CHANNEL_MODE_FSM_MACROS_SVH
`define BUTTON_PRESS_CHANNEL_MODE_FSM_MACROS_SVH

// Same-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define BPCM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define BPCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bpcm_pkg.sv -----
// Types, codes and defaults for the button press channel mode machine.
package bpcm_pkg;

  localparam int unsigned ChannelsDefault = 10;
  localparam logic [15:0] LongPressReset  = 16'd4000;
  localparam int unsigned TickW           = 16;

  // Press classes.
  localparam logic [1:0] ClassNone  = 2'd0;
  localparam logic [1:0] ClassShort = 2'd1;
  localparam logic [1:0] ClassLong  = 2'd2;

  // LED colour codes.
  localparam logic [2:0] LedYellow     = 3'd0;
  localparam logic [2:0] LedGreen      = 3'd1;
  localparam logic [2:0] LedRed        = 3'd2;
  localparam logic [2:0] LedGreenBlink = 3'd3;
  localparam logic [2:0] LedBlinkBase  = 3'd4;

  // Threshold setting codes.
  localparam logic [1:0] SetTen    = 2'd0;
  localparam logic [1:0] SetTwenty = 2'd1;
  localparam logic [1:0] SetThirty = 2'd2;

  // Per-channel mode, one-hot.
  typedef enum logic [6:0] {
    ModeOff     = 7'b0000001,
    ModeReady   = 7'b0000010,
    ModeMonitor = 7'b0000100,
    ModeSet10   = 7'b0001000,
    ModeSet20   = 7'b0010000,
    ModeSet30   = 7'b0100000,
    ModeFault   = 7'b1000000
  } mode_e;

  // Input transaction fields, last field in the lowest bits.
  typedef struct packed {
    logic       enter_fault;
    logic       cable_ok;
    logic       pressed;
    logic [3:0] channel;
  } item_t;

  // Result transaction fields, last field in the lowest bits.
  typedef struct packed {
    logic [1:0] setting_code;
    logic       setting_valid;
    logic       clear_alarms;
    logic       ack_break;
    logic       monitoring;
    logic [2:0] led_code;
    logic [1:0] press_class;
    logic [2:0] mode_now;
  } result_t;

  // Numeric mode as reported on the result.
  function automatic logic [2:0] mode_code(mode_e m);
    logic [2:0] code;
    unique case (m)
      ModeOff:     code = 3'd0;
      ModeReady:   code = 3'd1;
      ModeMonitor: code = 3'd2;
      ModeSet10:   code = 3'd3;
      ModeSet20:   code = 3'd4;
      ModeSet30:   code = 3'd5;
      ModeFault:   code = 3'd6;
      default:     code = 3'd0;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/button_press_channel_mode_fsm.sv -----
// Top level: per-channel button press classifier and channel mode machine.

// One transaction in, one transaction out, at up to one item per clock cycle.
// An accepted item sits in an input register, where that channel's state flops
// are read, the press is classified and the mode is advanced; once the result
// register is free or draining, both the channel state and the result register
// are written together. Items for the same channel may follow each other
// directly, because the channel state is updated at the edge at which the
// following item enters the input register. The input side keeps accepting
// while a result waits, until both the input register and the result register
// are full. Channels at or above CHANNELS give an all-zero result and leave
// all state untouched. The long-press time is written over the configuration
// channel, which is always ready, and should only change while no item is in
// flight.
`include "button_press_channel_mode_fsm_macros.svh"

module button_press_channel_mode_fsm #(
  parameter int unsigned CHANNELS = bpcm_pkg::ChannelsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration channel: long_press_ticks.
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // Input items.
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  // [3:0] channel, [4] pressed, [5] cable_ok, [6] enter_fault, [7] zero
  input  logic [7:0] s_axis_tdata_i,
  // Result items.
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  // [2:0] mode_now, [4:3] press_class, [7:5] led_code, [8] monitoring,
  // [9] ack_break, [10] clear_alarms, [11] setting_valid,
  // [13:12] setting_code, [15:14] zero
  output logic [15:0] m_axis_tdata_o
);
  import bpcm_pkg::*;

  localparam int unsigned ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned ChExtW = 6;
  localparam int unsigned ResW   = $bits(result_t);

  // Configuration register.
  logic [TickW-1:0] long_q;

  // Pipeline registers.
  logic    in_valid_q;
  item_t   in_q;
  logic    out_valid_q;
  result_t res_q;
  logic    advance;

  // Per-channel state.
  mode_e            mode_q [CHANNELS];
  logic [TickW-1:0] hold_q [CHANNELS];
  logic             rel_q  [CHANNELS];

  // Compute stage signals.
  logic [ChExtW-1:0] ch_ext;
  logic [ChIdxW-1:0] idx;
  logic              in_range;
  mode_e             cur_mode;
  mode_e             mode_d;
  logic [TickW-1:0]  hold_d;
  logic              rel_d;
  logic              state_wr;
  result_t           res_d;
  logic [1:0]        cls;
  logic [TickW-1:0]  cls_hold;
  logic              cls_rel;
  logic [TickW-1:0]  hold_cur;
  logic [TickW-1:0]  hold_inc;
  logic [TickW-1:0]  short_floor;

  // Handshake: the compute stage moves when the result register is free or draining.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(16 - ResW){1'b0}}, res_q};

  // Configuration register write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_q <= LongPressReset;
    end else if (cfg_valid_i) begin
      long_q <= cfg_data_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_q <= item_t'(s_axis_tdata_i[$bits(item_t)-1:0]);
    end
  end

  // Channel selection.
  assign ch_ext   = {{(ChExtW - 4){1'b0}}, in_q.channel};
  assign in_range = (ch_ext < ChExtW'(CHANNELS));
  assign idx      = ch_ext[ChIdxW-1:0];
  assign hold_cur = hold_q[idx];

  // Press classification for the selected channel.
  assign short_floor = {4'b0000, long_q[TickW-1:4]};
  assign hold_inc    = (hold_cur == {TickW{1'b1}}) ? hold_cur : hold_cur + TickW'(1);

  always_comb begin
    cls      = ClassNone;
    cls_hold = hold_cur;
    cls_rel  = rel_q[idx];
    if (!in_q.pressed) begin
      cls_rel = 1'b1;
      if (hold_cur <= short_floor) begin
        cls_hold = '0;
      end else if (hold_cur <= long_q) begin
        cls_hold = '0;
        cls      = ClassShort;
      end
    end else if (rel_q[idx]) begin
      if (hold_inc >= long_q) begin
        cls_hold = '0;
        cls_rel  = 1'b0;
        cls      = ClassLong;
      end else begin
        cls_hold = hold_inc;
      end
    end
  end

  // Mode machine and result for the selected channel.
  always_comb begin
    cur_mode = in_q.enter_fault ? ModeFault : mode_q[idx];
    mode_d   = cur_mode;
    hold_d   = cls_hold;
    rel_d    = cls_rel;
    state_wr = in_range;
    res_d    = '0;
    res_d.press_class = cls;
    unique case (cur_mode)
      ModeOff: begin
        res_d.ack_break = 1'b1;
        res_d.led_code  = LedYellow;
        if (cls == ClassShort) begin
          mode_d = ModeReady;
        end else if (cls == ClassLong) begin
          mode_d = ModeSet10;
        end
      end
      ModeReady: begin
        res_d.ack_break = 1'b1;
        res_d.led_code  = LedGreenBlink;
        if (cls == ClassShort) begin
          mode_d = ModeMonitor;
        end
      end
      ModeMonitor: begin
        res_d.ack_break  = (cls != ClassNone);
        res_d.led_code   = in_q.cable_ok ? LedGreen : LedRed;
        res_d.monitoring = 1'b1;
        if (cls == ClassLong) begin
          mode_d = ModeOff;
        end
      end
      ModeSet10: begin
        res_d.led_code = LedBlinkBase;
        if (cls == ClassShort) begin
          mode_d = ModeSet20;
        end else if (cls == ClassLong) begin
          mode_d              = ModeMonitor;
          res_d.setting_valid = 1'b1;
          res_d.setting_code  = SetTen;
        end
      end
      ModeSet20: begin
        res_d.led_code = LedBlinkBase + 3'd1;
        if (cls == ClassShort) begin
          mode_d = ModeSet30;
        end else if (cls == ClassLong) begin
          mode_d              = ModeMonitor;
          res_d.setting_valid = 1'b1;
          res_d.setting_code  = SetTwenty;
        end
      end
      ModeSet30: begin
        res_d.led_code = LedBlinkBase + 3'd2;
        if (cls == ClassShort) begin
          mode_d = ModeSet10;
        end else if (cls == ClassLong) begin
          mode_d              = ModeMonitor;
          res_d.setting_valid = 1'b1;
          res_d.setting_code  = SetThirty;
        end
      end
      ModeFault: begin
        res_d.led_code   = LedRed;
        res_d.monitoring = 1'b1;
        if (cls != ClassNone) begin
          res_d.clear_alarms = 1'b1;
          res_d.ack_break    = 1'b1;
          mode_d             = (cls == ClassShort) ? ModeMonitor : ModeOff;
        end
      end
      default: begin
        // An unknown stored mode falls back to off and leaves the press timing alone.
        mode_d = ModeOff;
        hold_d = hold_cur;
        rel_d  = rel_q[idx];
        res_d  = '0;
      end
    endcase
    res_d.mode_now = mode_code(mode_d);
    if (!in_range) begin
      res_d = '0;
    end
  end

  // Channel state update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        mode_q[i] <= ModeOff;
        hold_q[i] <= '0;
        rel_q[i]  <= 1'b0;
      end
    end else if (advance && state_wr) begin
      mode_q[idx] <= mode_d;
      hold_q[idx] <= hold_d;
      rel_q[idx]  <= rel_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  // Checks on the compute stage and result register.
  `BPCM_ASSERT_NOW(a_setting_on_long, out_valid_q && res_q.setting_valid,
    res_q.press_class == ClassLong && res_q.mode_now == 3'd2,
    "threshold setting written without a long press")
  `BPCM_ASSERT_NOW(a_clear_has_ack, out_valid_q && res_q.clear_alarms,
    res_q.ack_break && res_q.press_class != ClassNone,
    "alarms cleared without an acknowledged press")
  `BPCM_ASSERT_NOW(a_mode_onehot, advance && in_range, $onehot(mode_q[idx]),
    "stored channel mode is not one-hot")
  `BPCM_ASSERT_NEXT(a_result_follows, advance, out_valid_q,
    "compute stage moved but no result is held")

endmodule
